/* sv/mbpm_pkg.sv */
package mbpm_pkg;

	localparam int COUNT_BITS = 48;
	localparam int LIMIT_BITS = 48;
	localparam int LEVEL_BITS = 3;

	localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 48'd67108864;

	localparam logic [LIMIT_BITS-1:0] LOW_INTERVAL     = 48'h0000_8000_0000;
	localparam logic [LIMIT_BITS-1:0] MEDIUM_INTERVAL  = 48'h0000_2000_0000;
	localparam logic [LIMIT_BITS-1:0] HIGH_INTERVAL    = 48'h0000_0800_0000;
	localparam logic [LIMIT_BITS-1:0] EXTREME_INTERVAL = 48'h0000_0010_0000;

	localparam logic [1:0] KIND_ALLOC   = 2'd0;
	localparam logic [1:0] KIND_RELEASE = 2'd1;
	localparam logic [1:0] KIND_QUERY   = 2'd2;

	localparam logic [LEVEL_BITS-1:0] LEVEL_NONE    = 3'd0;
	localparam logic [LEVEL_BITS-1:0] LEVEL_LOW     = 3'd1;
	localparam logic [LEVEL_BITS-1:0] LEVEL_MEDIUM  = 3'd2;
	localparam logic [LEVEL_BITS-1:0] LEVEL_HIGH    = 3'd3;
	localparam logic [LEVEL_BITS-1:0] LEVEL_EXTREME = 3'd4;

	typedef struct packed {
		logic [1:0]            kind;
		logic [LIMIT_BITS-1:0] amount;
	} in_item_t;

	typedef struct packed {
		logic                  granted;
		logic [LEVEL_BITS-1:0] pressure_level;
		logic                  advise_pressure;
		logic [LIMIT_BITS-1:0] used_now;
		logic [LIMIT_BITS-1:0] free_now;
		logic                  underflow;
	} out_item_t;

	typedef struct packed {
		logic [LIMIT_BITS-1:0] t_low;
		logic [LIMIT_BITS-1:0] t_med;
		logic [LIMIT_BITS-1:0] t_high;
		logic [LIMIT_BITS-1:0] t_ext;
	} thresholds_t;

	function automatic logic [LIMIT_BITS-1:0] threshold(
		input logic [LIMIT_BITS-1:0] limit,
		input logic [LIMIT_BITS-1:0] interval
	);
		threshold = (interval > limit) ? '0 : limit - interval;
	endfunction

	function automatic thresholds_t make_thresholds(input logic [LIMIT_BITS-1:0] limit);
		thresholds_t t;
		t.t_low  = threshold(limit, LOW_INTERVAL);
		t.t_med  = threshold(limit, MEDIUM_INTERVAL);
		t.t_high = threshold(limit, HIGH_INTERVAL);
		t.t_ext  = threshold(limit, EXTREME_INTERVAL);
		return t;
	endfunction

endpackage

/* sv/mbpm_step.sv */
module mbpm_step (
	input  mbpm_pkg::in_item_t                     item,
	input  logic [mbpm_pkg::COUNT_BITS-1:0]        used,
	input  logic [mbpm_pkg::LEVEL_BITS-1:0]        level,
	input  logic [mbpm_pkg::LIMIT_BITS-1:0]        limit,
	input  mbpm_pkg::thresholds_t                  thr,
	output mbpm_pkg::out_item_t                    result,
	output logic [mbpm_pkg::COUNT_BITS-1:0]        used_next,
	output logic [mbpm_pkg::LEVEL_BITS-1:0]        level_next
);
	import mbpm_pkg::*;

	logic [COUNT_BITS:0]   sum;
	logic [COUNT_BITS:0]   limit_ext;
	logic                  fits;
	logic [COUNT_BITS-1:0] u;
	logic [LEVEL_BITS-1:0] lvl_eval;
	logic                  advise_eval;
	logic [COUNT_BITS:0]   free_diff;
	logic                  granted;
	logic                  under;

	assign sum       = {1'b0, used} + (COUNT_BITS+1)'(item.amount);
	assign limit_ext = (COUNT_BITS+1)'(limit);
	assign fits      = (sum <= limit_ext);
	assign u         = sum[COUNT_BITS-1:0];

	always_comb begin
		lvl_eval    = level;
		advise_eval = 1'b0;
		unique case (level)
			LEVEL_NONE: begin
				if (u >= COUNT_BITS'(thr.t_low)) lvl_eval = LEVEL_LOW;
			end
			LEVEL_LOW: begin
				if (u >= COUNT_BITS'(thr.t_med)) lvl_eval = LEVEL_MEDIUM;
				else if (u < COUNT_BITS'(thr.t_low)) lvl_eval = LEVEL_NONE;
			end
			LEVEL_MEDIUM: begin
				if (u >= COUNT_BITS'(thr.t_high)) lvl_eval = LEVEL_HIGH;
				else if (u < COUNT_BITS'(thr.t_med)) lvl_eval = LEVEL_LOW;
			end
			LEVEL_HIGH: begin
				if (u >= COUNT_BITS'(thr.t_ext)) begin
					lvl_eval    = LEVEL_EXTREME;
					advise_eval = 1'b1;
				end else if (u < COUNT_BITS'(thr.t_high)) begin
					lvl_eval = LEVEL_MEDIUM;
				end
			end
			LEVEL_EXTREME: begin
				if (u < COUNT_BITS'(thr.t_ext)) lvl_eval = LEVEL_HIGH;
			end
			default: begin
				lvl_eval = LEVEL_NONE;
			end
		endcase
	end

	always_comb begin
		used_next  = used;
		level_next = level;
		granted    = 1'b0;
		under      = 1'b0;
		case (item.kind)
			KIND_ALLOC: begin
				if (fits) begin
					granted    = 1'b1;
					used_next  = u;
					level_next = lvl_eval;
				end
			end
			KIND_RELEASE: begin
				if (COUNT_BITS'(item.amount) > used) begin
					used_next = '0;
					under     = 1'b1;
				end else begin
					used_next = used - COUNT_BITS'(item.amount);
				end
			end
			default: begin
			end
		endcase
	end

	assign free_diff = limit_ext - {1'b0, used_next};

	always_comb begin
		result.granted         = granted;
		result.pressure_level  = level_next;
		result.advise_pressure = granted & advise_eval;
		result.used_now        = LIMIT_BITS'(used_next);
		result.free_now        = free_diff[COUNT_BITS] ? '0 : LIMIT_BITS'(free_diff);
		result.underflow       = under;
	end

endmodule

/* sv/memory_budget_pressure_monitor_core.sv */
// channel | direction | handshake          | payload
// in      | input     | in_valid / in_stall   | in_item_t  (kind, amount)
// out     | output    | out_valid / out_stall | out_item_t (granted .. underflow)
// cfg     | input     | cfg_valid / cfg_ready | byte_limit, 48 bits
//
// One transaction per cycle sustained while out_stall is low; out_valid rises as a
// transaction moves from the input register into the result register, and the used-byte
// counter and pressure level update at that move, so the next one sees them with no bubble.
// Reset clears counter and level and loads the limit with 64 MiB.
// in_stall rises only when the input register is full and the result register is stalled.
module memory_budget_pressure_monitor_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  mbpm_pkg::in_item_t           in_data,
	output logic                         out_valid,
	input  logic                         out_stall,
	output mbpm_pkg::out_item_t          out_data,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [mbpm_pkg::LIMIT_BITS-1:0] cfg_data
);
	import mbpm_pkg::*;

	logic                  valid_s1;
	in_item_t              item_s1;
	logic [COUNT_BITS-1:0] used_q;
	logic [LEVEL_BITS-1:0] level_q;
	logic [LIMIT_BITS-1:0] limit_q;
	thresholds_t           thr_q;
	logic                  out_valid_q;
	out_item_t             out_q;

	out_item_t             result;
	logic [COUNT_BITS-1:0] used_next;
	logic [LEVEL_BITS-1:0] level_next;
	logic                  out_ready;
	logic                  advance;
	logic                  in_take;

	assign out_ready = !out_valid_q || !out_stall;
	assign advance   = valid_s1 && out_ready;
	assign in_stall  = valid_s1 && !out_ready;
	assign in_take   = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	mbpm_step u_step (
		.item       (item_s1),
		.used       (used_q),
		.level      (level_q),
		.limit      (limit_q),
		.thr        (thr_q),
		.result     (result),
		.used_next  (used_next),
		.level_next (level_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
			thr_q   <= make_thresholds(LIMIT_RESET);
		end else if (cfg_valid && cfg_ready) begin
			limit_q <= cfg_data;
			thr_q   <= make_thresholds(cfg_data);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			used_q      <= '0;
			level_q     <= LEVEL_NONE;
		end else begin
			if (in_take) valid_s1 <= 1'b1;
			else if (advance) valid_s1 <= 1'b0;
			if (advance) begin
				out_valid_q <= 1'b1;
				used_q      <= used_next;
				level_q     <= level_next;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) item_s1 <= in_data;
		if (advance) out_q <= result;
	end

endmodule

/* dv/memory_budget_pressure_monitor_core_tb.sv */
`timescale 1ns / 1ps

module memory_budget_pressure_monitor_core_tb;
	import mbpm_pkg::*;

	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int QUIET_LIMIT = 2000;
	localparam int DRAIN_SLACK = 4;
	localparam logic [LIMIT_BITS-1:0] LIMIT_MAX = '1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [LIMIT_BITS-1:0] cfg_data = '0;

	// predictor state
	logic [LIMIT_BITS-1:0] byte_budget = LIMIT_RESET;
	logic [COUNT_BITS-1:0] bytes_in_use = '0;
	logic [LEVEL_BITS-1:0] pressure = LEVEL_NONE;

	out_item_t expected_results[$];
	bit gaps_on = 1'b1;
	int mismatches = 0;
	int results_seen = 0;
	int requests_sent = 0;
	int grants = 0;
	int releases = 0;
	int queries = 0;
	int advisories = 0;
	int limit_writes = 0;
	int quiet_cycles = 0;

	memory_budget_pressure_monitor_core u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [LIMIT_BITS-1:0] level_floor(input logic [LIMIT_BITS-1:0] gap);
		return (gap > byte_budget) ? '0 : byte_budget - gap;
	endfunction

	function automatic out_item_t predict_budget_step(input in_item_t req);
		out_item_t res;
		logic [COUNT_BITS:0] sum;
		logic [LIMIT_BITS-1:0] fl_low, fl_med, fl_high, fl_ext;
		res = '0;
		fl_low = level_floor(LOW_INTERVAL);
		fl_med = level_floor(MEDIUM_INTERVAL);
		fl_high = level_floor(HIGH_INTERVAL);
		fl_ext = level_floor(EXTREME_INTERVAL);
		case (req.kind)
			KIND_ALLOC: begin
				sum = {1'b0, bytes_in_use} + {1'b0, req.amount};
				if (!sum[COUNT_BITS] && sum[COUNT_BITS-1:0] <= byte_budget) begin
					bytes_in_use = sum[COUNT_BITS-1:0];
					res.granted = 1'b1;
					case (pressure)
						LEVEL_NONE: begin
							if (bytes_in_use >= fl_low) pressure = LEVEL_LOW;
						end
						LEVEL_LOW: begin
							if (bytes_in_use >= fl_med) pressure = LEVEL_MEDIUM;
							else if (bytes_in_use < fl_low) pressure = LEVEL_NONE;
						end
						LEVEL_MEDIUM: begin
							if (bytes_in_use >= fl_high) pressure = LEVEL_HIGH;
							else if (bytes_in_use < fl_med) pressure = LEVEL_LOW;
						end
						LEVEL_HIGH: begin
							if (bytes_in_use >= fl_ext) begin
								pressure = LEVEL_EXTREME;
								res.advise_pressure = 1'b1;
							end else if (bytes_in_use < fl_high) begin
								pressure = LEVEL_MEDIUM;
							end
						end
						LEVEL_EXTREME: begin
							if (bytes_in_use < fl_ext) pressure = LEVEL_HIGH;
						end
						default: pressure = LEVEL_NONE;
					endcase
				end
			end
			KIND_RELEASE: begin
				if (req.amount > bytes_in_use) begin
					bytes_in_use = '0;
					res.underflow = 1'b1;
				end else begin
					bytes_in_use = bytes_in_use - req.amount;
				end
			end
			default: ;
		endcase
		res.pressure_level = pressure;
		res.used_now = bytes_in_use;
		res.free_now = (byte_budget > bytes_in_use) ? byte_budget - bytes_in_use : '0;
		return res;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("ERROR: %s", msg);
		mismatches++;
	endtask

	task automatic compare_field(input string field, input logic [LIMIT_BITS-1:0] got,
			input logic [LIMIT_BITS-1:0] want);
		if (got !== want)
			report_mismatch($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
				results_seen, field, got, want));
	endtask

	// result checker and watchdog
	always @(posedge clk) begin
		out_item_t want;
		if (out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				report_mismatch($sformatf("result %0d with no transaction pending", results_seen));
			end else begin
				want = expected_results.pop_front();
				compare_field("granted", LIMIT_BITS'(out_data.granted),
					LIMIT_BITS'(want.granted));
				compare_field("pressure_level", LIMIT_BITS'(out_data.pressure_level),
					LIMIT_BITS'(want.pressure_level));
				compare_field("advise_pressure", LIMIT_BITS'(out_data.advise_pressure),
					LIMIT_BITS'(want.advise_pressure));
				compare_field("used_now", out_data.used_now, want.used_now);
				compare_field("free_now", out_data.free_now, want.free_now);
				compare_field("underflow", LIMIT_BITS'(out_data.underflow),
					LIMIT_BITS'(want.underflow));
			end
			results_seen++;
		end
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("ERROR: no transaction for %0d cycles", QUIET_LIMIT);
			$display("memory_budget_pressure_monitor_core: mismatch");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	always @(posedge clk) begin
		out_stall <= gaps_on && ($urandom_range(0, 99) < 24);
	end

	task automatic send_item(input logic [1:0] kind, input logic [LIMIT_BITS-1:0] amount);
		in_item_t req;
		out_item_t res;
		req.kind = kind;
		req.amount = amount;
		if (gaps_on && $urandom_range(0, 99) < 20) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 2)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= req;
		do @(posedge clk); while (in_stall);
		res = predict_budget_step(req);
		expected_results.push_back(res);
		requests_sent++;
		grants += int'(res.granted);
		advisories += int'(res.advise_pressure);
		if (kind == KIND_RELEASE) releases++;
		if (kind == KIND_QUERY || kind == KIND_UNUSED) queries++;
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (DRAIN_SLACK) @(posedge clk);
	endtask

	task automatic write_limit(input logic [LIMIT_BITS-1:0] value);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		byte_budget = value;
		limit_writes++;
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [LIMIT_BITS-1:0] rand_wide();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[LIMIT_BITS-1:0];
	endfunction

	// amounts aimed at the thresholds, the limit and the current usage
	function automatic logic [LIMIT_BITS-1:0] pick_amount(input logic [1:0] kind);
		logic [LIMIT_BITS-1:0] target;
		logic [LIMIT_BITS-1:0] room;
		room = (byte_budget > bytes_in_use) ? byte_budget - bytes_in_use : '0;
		if (kind != KIND_ALLOC && kind != KIND_RELEASE) return rand_wide();
		case ($urandom_range(0, 9))
			0: return rand_wide();
			1: return LIMIT_BITS'($urandom_range(0, 255));
			2, 3, 4, 5: begin
				case ($urandom_range(0, 4))
					0: target = level_floor(LOW_INTERVAL);
					1: target = level_floor(MEDIUM_INTERVAL);
					2: target = level_floor(HIGH_INTERVAL);
					3: target = level_floor(EXTREME_INTERVAL);
					default: target = byte_budget;
				endcase
				target = target - 4 + LIMIT_BITS'($urandom_range(0, 8));
				if (kind == KIND_ALLOC)
					return (target >= bytes_in_use) ? target - bytes_in_use
						: LIMIT_BITS'($urandom_range(0, 64));
				return (bytes_in_use >= target) ? bytes_in_use - target
					: LIMIT_BITS'($urandom_range(0, 64));
			end
			6, 7: return byte_budget >> $urandom_range(1, 12);
			8: return (kind == KIND_ALLOC) ? room : bytes_in_use;
			default: return (kind == KIND_ALLOC) ? room + 1 : bytes_in_use + 1;
		endcase
	endfunction

	task automatic test_reset_limit_corners();
		send_item(KIND_QUERY, LIMIT_MAX);
		send_item(KIND_UNUSED, LIMIT_MAX);
		send_item(KIND_RELEASE, '0);
		send_item(KIND_RELEASE, 48'd5);
		send_item(KIND_ALLOC, LIMIT_MAX);
		send_item(KIND_ALLOC, LIMIT_RESET);
		repeat (3) send_item(KIND_ALLOC, '0);
		send_item(KIND_RELEASE, 48'h0000_0020_0000);
		send_item(KIND_ALLOC, '0);
		send_item(KIND_RELEASE, LIMIT_MAX);
	endtask

	task automatic test_limit_extremes();
		write_limit('0);
		send_item(KIND_ALLOC, '0);
		send_item(KIND_ALLOC, 48'd1);
		write_limit(LIMIT_MAX);
		send_item(KIND_ALLOC, LIMIT_MAX);
		send_item(KIND_ALLOC, 48'd1);
		write_limit(48'd4096);
		send_item(KIND_QUERY, '0);
		send_item(KIND_ALLOC, '0);
		send_item(KIND_RELEASE, LIMIT_MAX);
	endtask

	task automatic test_pressure_ramp();
		write_limit(48'h0001_0000_0000);
		send_item(KIND_ALLOC, 48'h0000_8000_0000);
		send_item(KIND_ALLOC, 48'h0000_6000_0000);
		send_item(KIND_ALLOC, 48'h0000_1800_0000);
		send_item(KIND_ALLOC, 48'h0000_07F0_0000);
		send_item(KIND_RELEASE, 48'd1);
		send_item(KIND_ALLOC, '0);
	endtask

	task automatic run_random_phase(input logic [LIMIT_BITS-1:0] limit, input int count);
		logic [1:0] kind;
		int pick;
		write_limit(limit);
		repeat (count) begin
			pick = $urandom_range(0, 99);
			if (pick < 50) kind = KIND_ALLOC;
			else if (pick < 80) kind = KIND_RELEASE;
			else if (pick < 95) kind = KIND_QUERY;
			else kind = KIND_UNUSED;
			send_item(kind, pick_amount(kind));
		end
	endtask

	task automatic test_random_traffic();
		run_random_phase(LIMIT_RESET, 300);
		gaps_on = 1'b0;
		run_random_phase(48'h0000_C000_0000 + LIMIT_BITS'($urandom_range(0, 1 << 20)), 300);
		gaps_on = 1'b1;
		run_random_phase(rand_wide(), 300);
		run_random_phase(48'd5000, 300);
		run_random_phase(LIMIT_MAX, 300);
		run_random_phase(48'h0000_8000_0000, 300);
	endtask

	task automatic finish_run();
		wait_idle();
		$display("%0d requests (%0d grants, %0d releases, %0d queries, %0d advisories)",
			requests_sent, grants, releases, queries, advisories);
		$display("%0d results checked across %0d limit writes", results_seen, limit_writes);
		if (mismatches == 0) begin
			$display("memory_budget_pressure_monitor_core: match");
		end else begin
			$display("memory_budget_pressure_monitor_core: mismatch");
		end
		$finish;
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_limit_corners();
		test_limit_extremes();
		test_pressure_ramp();
		test_random_traffic();
		finish_run();
	end

endmodule
